/* rtl/gvpu_pkg.sv */
// Shared types and constants of the grid value predict/update block.
// No dependencies; imported by every module of the block.
package gvpu_pkg;

	localparam int DATA_W  = 32;
	localparam int DEPTH   = 1024;
	localparam int ADDR_W  = 10;
	localparam int KERN_W  = 16;
	localparam int STEP_W  = 16;
	localparam int OP_W    = 2;
	localparam int ACT_W   = 2;
	localparam int CFG_W   = 3;
	localparam int TAP_W   = 3;
	localparam int PROD_W  = DATA_W + KERN_W;
	localparam int ACC_W   = PROD_W + 3;
	localparam int PRED_W  = ACC_W - 14;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PREDICT = 2'd0;
	localparam logic [OP_W-1:0] OP_UPDATE  = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE   = 2'd2;
	localparam logic [OP_W-1:0] OP_READ    = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_W-1:0] CFG_MIN_X       = 3'd0;
	localparam logic [CFG_W-1:0] CFG_MIN_Y       = 3'd1;
	localparam logic [CFG_W-1:0] CFG_INV_WIDTH_X = 3'd2;
	localparam logic [CFG_W-1:0] CFG_INV_WIDTH_Y = 3'd3;
	localparam logic [CFG_W-1:0] CFG_STEP_SIZE   = 3'd4;
	localparam logic [CFG_W-1:0] CFG_K_CENTER    = 3'd5;
	localparam logic [CFG_W-1:0] CFG_K_NEAR      = 3'd6;
	localparam logic [CFG_W-1:0] CFG_K_FAR       = 3'd7;

	// Controller to datapath commands
	typedef struct packed {
		logic              load;
		logic              mul_x;
		logic              mul_y;
		logic              cell_ld;
		logic              acc_clr;
		logic              rd_tap;
		logic              mul_tap;
		logic              acc_add;
		logic              err;
		logic              step;
		logic              urd;
		logic              uwr;
		logic              wr_entry;
		logic              rd_entry;
		logic              clr_wr;
		logic [ADDR_W-1:0] clr_addr;
		logic [TAP_W-1:0]  tap;
		logic              out_load;
	} gvpu_cmd_t;

	// Saturate to a signed 32-bit value
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (x < -64'sd2147483648)
			return 32'sh80000000;
		else
			return x[DATA_W-1:0];
	endfunction

endpackage

/* rtl/gvpu_ctrl.sv */
// Sequencing state machine: table clear, cell lookup, tap reads, update write-back.
// Depends on gvpu_pkg.
module gvpu_ctrl import gvpu_pkg::*; #(
	parameter int KERNEL_TAPS = 3
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [OP_W-1:0] operation,
	output logic            out_valid,
	input  logic            out_stall,
	output gvpu_cmd_t       cmd
);

	localparam int NTAPS = 2 * KERNEL_TAPS - 1;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_CX   = 4'd2;
	localparam logic [3:0] S_CY   = 4'd3;
	localparam logic [3:0] S_CELL = 4'd4;
	localparam logic [3:0] S_PRD  = 4'd5;
	localparam logic [3:0] S_PMUL = 4'd6;
	localparam logic [3:0] S_PACC = 4'd7;
	localparam logic [3:0] S_ERR  = 4'd8;
	localparam logic [3:0] S_STEP = 4'd9;
	localparam logic [3:0] S_URD  = 4'd10;
	localparam logic [3:0] S_UWR  = 4'd11;
	localparam logic [3:0] S_WR   = 4'd12;
	localparam logic [3:0] S_RD   = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	logic [3:0]        state_q, state_d;
	logic [ADDR_W-1:0] clr_q;
	logic [TAP_W-1:0]  tap_q;
	logic [OP_W-1:0]   op_q;
	logic              out_valid_q;
	logic              last_tap;
	logic              slot_free;

	assign last_tap  = (tap_q == TAP_W'(NTAPS - 1));
	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.clr_addr = clr_q;
		cmd.tap      = tap_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (clr_q == ADDR_W'(DEPTH - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					unique case (operation) inside
						OP_PREDICT, OP_UPDATE: state_d = S_CX;
						OP_WRITE:              state_d = S_WR;
						default:               state_d = S_RD;
					endcase
				end
			end
			S_CX: begin
				cmd.mul_x = 1'b1;
				state_d   = S_CY;
			end
			S_CY: begin
				cmd.mul_y = 1'b1;
				state_d   = S_CELL;
			end
			S_CELL: begin
				cmd.cell_ld = 1'b1;
				cmd.acc_clr = 1'b1;
				state_d     = S_PRD;
			end
			S_PRD: begin
				cmd.rd_tap = 1'b1;
				state_d    = S_PMUL;
			end
			S_PMUL: begin
				cmd.mul_tap = 1'b1;
				state_d     = S_PACC;
			end
			S_PACC: begin
				cmd.acc_add = 1'b1;
				if (!last_tap)
					state_d = S_PRD;
				else if (op_q == OP_UPDATE)
					state_d = S_ERR;
				else
					state_d = S_DONE;
			end
			S_ERR: begin
				cmd.err = 1'b1;
				state_d = S_STEP;
			end
			S_STEP: begin
				cmd.step = 1'b1;
				state_d  = S_URD;
			end
			S_URD: begin
				cmd.urd = 1'b1;
				state_d = S_UWR;
			end
			S_UWR: begin
				cmd.uwr = 1'b1;
				state_d = last_tap ? S_DONE : S_URD;
			end
			S_WR: begin
				cmd.wr_entry = 1'b1;
				state_d      = S_DONE;
			end
			S_RD: begin
				cmd.rd_entry = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			tap_q       <= '0;
			op_q        <= OP_PREDICT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR)
				clr_q <= clr_q + 1'b1;
			if (cmd.load)
				op_q <= operation;
			if (cmd.cell_ld || (state_q == S_PACC && last_tap))
				tap_q <= '0;
			else if ((state_q == S_PACC) || (state_q == S_UWR))
				tap_q <= tap_q + 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

/* rtl/gvpu_dpath.sv */
// Datapath: configuration registers, cell arithmetic, value table, MAC and update.
// Depends on gvpu_pkg.
module gvpu_dpath import gvpu_pkg::*; #(
	parameter int ACTIONS  = 4,
	parameter int SEGMENTS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gvpu_cmd_t                cmd,
	input  logic                     cfg_valid,
	input  logic [CFG_W-1:0]         cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	input  logic [OP_W-1:0]          operation,
	input  logic signed [DATA_W-1:0] state_x,
	input  logic signed [DATA_W-1:0] state_y,
	input  logic [ACT_W-1:0]         action,
	input  logic signed [DATA_W-1:0] target,
	input  logic [ADDR_W-1:0]        entry_index,
	input  logic signed [DATA_W-1:0] entry_value,
	output logic signed [DATA_W-1:0] result_value,
	output logic [OP_W-1:0]          result_kind
);

	localparam int CW     = $clog2(SEGMENTS);
	localparam int CELL_W = $clog2(SEGMENTS * SEGMENTS);
	localparam int PLANE  = SEGMENTS * SEGMENTS;
	localparam int AIW    = $clog2(ACTIONS + 3);

	// Configuration
	logic signed [DATA_W-1:0] min_x_q, min_y_q;
	logic [DATA_W-1:0]        inv_x_q, inv_y_q;
	logic [STEP_W-1:0]        step_q;
	logic signed [KERN_W-1:0] k_center_q, k_near_q, k_far_q;

	// Latched item
	logic [OP_W-1:0]          op_q;
	logic signed [DATA_W-1:0] state_x_q, state_y_q, target_q, entry_value_q;
	logic [ACT_W-1:0]         action_q;
	logic [ADDR_W-1:0]        entry_index_q;

	// Working registers
	logic [63:0]              mprod_q;
	logic [CW-1:0]            cx_q;
	logic [CELL_W-1:0]        cell_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [DATA_W-1:0] err_q;
	logic signed [48:0]       t_q;
	logic signed [63:0]       uprod_q;
	logic signed [DATA_W-1:0] rdata_q;
	logic signed [DATA_W-1:0] result_value_q;
	logic [OP_W-1:0]          result_kind_q;

	logic signed [DATA_W-1:0] mem [DEPTH];

	logic signed [DATA_W:0]   diff_c;
	logic [DATA_W-1:0]        mop_c, inv_c;
	logic [CW-1:0]            cclamp_c;
	logic [AIW-1:0]           act_c, ofs_c, sel_c;
	logic [31:0]              addr_full_c;
	logic [ADDR_W-1:0]        tap_addr_c;
	logic signed [KERN_W-1:0] w_c;
	logic signed [PRED_W-1:0] pred_c;
	logic signed [PRED_W:0]   diff_err_c;
	logic signed [16:0]       step_s_c;
	logic signed [63:0]       usum_c;
	logic                     we_c, re_c;
	logic [ADDR_W-1:0]        waddr_c, raddr_c;
	logic signed [DATA_W-1:0] wdata_c, res_c;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q    <= '0;
			min_y_q    <= '0;
			inv_x_q    <= 32'd65536;
			inv_y_q    <= 32'd65536;
			step_q     <= 16'd655;
			k_center_q <= 16'sd16384;
			k_near_q   <= '0;
			k_far_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MIN_X:       min_x_q    <= cfg_data;
				CFG_MIN_Y:       min_y_q    <= cfg_data;
				CFG_INV_WIDTH_X: inv_x_q    <= cfg_data;
				CFG_INV_WIDTH_Y: inv_y_q    <= cfg_data;
				CFG_STEP_SIZE:   step_q     <= cfg_data[STEP_W-1:0];
				CFG_K_CENTER:    k_center_q <= cfg_data[KERN_W-1:0];
				CFG_K_NEAR:      k_near_q   <= cfg_data[KERN_W-1:0];
				CFG_K_FAR:       k_far_q    <= cfg_data[KERN_W-1:0];
				default: ;
			endcase
		end
	end

	// Cell coordinate: offset from the lower edge, scaled, then clamped
	always_comb begin
		if (cmd.mul_y) begin
			diff_c = (DATA_W+1)'(state_y_q) - (DATA_W+1)'(min_y_q);
			inv_c  = inv_y_q;
		end else begin
			diff_c = (DATA_W+1)'(state_x_q) - (DATA_W+1)'(min_x_q);
			inv_c  = inv_x_q;
		end
		mop_c = (!diff_c[DATA_W] && (diff_c != '0)) ? diff_c[DATA_W-1:0] : '0;
		if (mprod_q[63:32] > 32'(SEGMENTS - 1))
			cclamp_c = CW'(SEGMENTS - 1);
		else
			cclamp_c = mprod_q[32 +: CW];
	end

	// Tap address and weight: odd taps go up, even taps go down
	always_comb begin
		if (AIW'(action_q) > AIW'(ACTIONS - 1))
			act_c = AIW'(ACTIONS - 1);
		else
			act_c = AIW'(action_q);
		ofs_c = AIW'(cmd.tap[2:1]) + AIW'(cmd.tap[0]);
		if (cmd.tap[0]) begin
			if (act_c + ofs_c > AIW'(ACTIONS - 1))
				sel_c = AIW'(ACTIONS - 1);
			else
				sel_c = act_c + ofs_c;
		end else begin
			sel_c = (act_c >= ofs_c) ? act_c - ofs_c : '0;
		end
		addr_full_c = 32'(cell_q) + 32'(sel_c) * 32'(PLANE);
		tap_addr_c  = addr_full_c[ADDR_W-1:0];
		case (ofs_c)
			AIW'(0): w_c = k_center_q;
			AIW'(1): w_c = k_near_q;
			default: w_c = k_far_q;
		endcase
	end

	// Prediction, error and update sum
	always_comb begin
		pred_c     = PRED_W'(acc_q >>> 14);
		diff_err_c = (PRED_W+1)'(target_q) - (PRED_W+1)'(pred_c);
		step_s_c   = {1'b0, step_q};
		usum_c     = 64'(rdata_q) + (uprod_q >>> 30);
	end

	// Table port selection
	always_comb begin
		we_c    = cmd.clr_wr || cmd.wr_entry || cmd.uwr;
		waddr_c = cmd.clr_wr ? cmd.clr_addr : (cmd.wr_entry ? entry_index_q : tap_addr_c);
		if (cmd.clr_wr)
			wdata_c = '0;
		else if (cmd.wr_entry)
			wdata_c = entry_value_q;
		else
			wdata_c = sat32(usum_c);
		re_c    = cmd.rd_tap || cmd.urd || cmd.rd_entry;
		raddr_c = cmd.rd_entry ? entry_index_q : tap_addr_c;
	end

	// Value table
	always_ff @(posedge clk) begin
		if (we_c)
			mem[waddr_c] <= wdata_c;
		if (re_c)
			rdata_q <= mem[raddr_c];
	end

	// Result selection
	always_comb begin
		case (op_q)
			OP_PREDICT: res_c = sat32(64'(pred_c));
			OP_UPDATE:  res_c = err_q;
			OP_WRITE:   res_c = '0;
			default:    res_c = rdata_q;
		endcase
	end

	// Item latch and arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q          <= operation;
			state_x_q     <= state_x;
			state_y_q     <= state_y;
			action_q      <= action;
			target_q      <= target;
			entry_index_q <= entry_index;
			entry_value_q <= entry_value;
		end
		if (cmd.mul_x || cmd.mul_y)
			mprod_q <= 64'(mop_c) * 64'(inv_c);
		if (cmd.mul_y)
			cx_q <= cclamp_c;
		if (cmd.cell_ld)
			cell_q <= CELL_W'(32'(cx_q) * 32'(SEGMENTS) + 32'(cclamp_c));
		if (cmd.mul_tap)
			prod_q <= PROD_W'(w_c * rdata_q);
		if (cmd.acc_clr)
			acc_q <= '0;
		else if (cmd.acc_add)
			acc_q <= acc_q + ACC_W'(prod_q);
		if (cmd.err)
			err_q <= sat32(64'(diff_err_c));
		if (cmd.step)
			t_q <= 49'(step_s_c * err_q);
		if (cmd.urd)
			uprod_q <= 64'(t_q * w_c);
		if (cmd.out_load) begin
			result_value_q <= res_c;
			result_kind_q  <= op_q;
		end
	end

	assign result_value = result_value_q;
	assign result_kind  = result_kind_q;

endmodule

/* rtl/grid_value_predict_update.sv */
// Top level of the grid value predict/update block: controller plus datapath.
// Depends on gvpu_pkg, gvpu_ctrl and gvpu_dpath.
//
// Usage:
//  Input channel (in_valid/in_stall) carries one operation per transaction:
//  predict, update, write entry or read entry. Output channel (out_valid/
//  out_stall) returns one result per input transaction, in order, with the
//  operation echoed in result_kind. Configuration writes use cfg_valid/
//  cfg_ready (always ready) with cfg_index and cfg_data; write only while idle.
//  Steps per item, from acceptance to result register load: predict scales
//   x, then y, forms the cell, then reads, multiplies and accumulates each of
//   T = 2*KERNEL_TAPS-1 taps; update then forms the error and the stepped error
//   and reads and writes back each tap; write and read access one entry.
//  One item is worked on at a time; the next is accepted as soon as the
//  result sits in the output register, even while that result is stalled.
//  After reset the table is cleared, one entry per cycle, all 1024 entries;
//  in_stall stays high meanwhile. A stalled result holds until taken.
module grid_value_predict_update import gvpu_pkg::*; #(
	parameter int ACTIONS     = 4,
	parameter int SEGMENTS    = 16,
	parameter int KERNEL_TAPS = 3
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [OP_W-1:0]          operation,
	input  logic signed [DATA_W-1:0] state_x,
	input  logic signed [DATA_W-1:0] state_y,
	input  logic [ACT_W-1:0]         action,
	input  logic signed [DATA_W-1:0] target,
	input  logic [ADDR_W-1:0]        entry_index,
	input  logic signed [DATA_W-1:0] entry_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] result_value,
	output logic [OP_W-1:0]          result_kind,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_W-1:0]         cfg_index,
	input  logic [DATA_W-1:0]        cfg_data
);

	gvpu_cmd_t cmd;

	assign cfg_ready = 1'b1;

	gvpu_ctrl #(
		.KERNEL_TAPS(KERNEL_TAPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.operation(operation),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd)
	);

	gvpu_dpath #(
		.ACTIONS (ACTIONS),
		.SEGMENTS(SEGMENTS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.operation   (operation),
		.state_x     (state_x),
		.state_y     (state_y),
		.action      (action),
		.target      (target),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.result_value(result_value),
		.result_kind (result_kind)
	);

endmodule

/* rtl/gvpu_chk.sv */
// Port-level checker for the grid value predict/update block, with its bind.
// Depends on gvpu_pkg.
module gvpu_chk import gvpu_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [DATA_W-1:0] result_value,
	input logic [OP_W-1:0]          result_kind,
	input logic                     cfg_ready
);

	// A stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(result_kind))
		else $error("stalled result changed");

	// One item at a time: busy right after an accepted transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while item in flight");

	// A new result only appears while the block was working on an item
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work");

	// Configuration is always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

endmodule

bind grid_value_predict_update gvpu_chk u_chk (.*);
